[src/tracker_binary_frame_deframer_macros.svh]
// ----------------------------------------------------------------------------
// Tracker binary frame deframer: assertion macros
// Shared concurrent assertion forms, all reset-qualified on the active-low
// synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TRACKER_BINARY_FRAME_DEFRAMER_MACROS_SVH
`define TRACKER_BINARY_FRAME_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbfd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbfd assertion failed");

`endif

[src/tbfd_pkg.sv]
// ----------------------------------------------------------------------------
// Tracker binary frame deframer package
// Frame geometry, sync constants and the decoded report type.
// ----------------------------------------------------------------------------
package tbfd_pkg;

    localparam int FRAME_LEN = 20;
    // Bytes held in the cell chain; the last frame byte comes straight from the input.
    localparam int CHAIN_LEN = FRAME_LEN - 1;
    localparam int COUNT_W   = $clog2(FRAME_LEN);

    localparam logic [7:0] SYNC_BIT    = 8'h80;
    localparam logic [7:0] LOW7        = 8'h7F;
    localparam logic [8:0] SENSOR_BASE = 9'h031;   // ASCII '1'

    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(CHAIN_LEN);

    typedef logic [7:0] t_byte;
    typedef t_byte t_frame [FRAME_LEN];

    typedef struct packed {
        logic signed [8:0]  sensor_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_result;

endpackage

[src/tbfd_cell.sv]
// ----------------------------------------------------------------------------
// Frame byte cell
// One stage of the byte chain: takes its neighbour's byte on every shift.
// ----------------------------------------------------------------------------
module tbfd_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  tbfd_pkg::t_byte  i_byte,
    output tbfd_pkg::t_byte  o_byte
);

    tbfd_pkg::t_byte r_byte;
    tbfd_pkg::t_byte n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

[src/tbfd_unpack.sv]
// ----------------------------------------------------------------------------
// Frame unpacker
// Restores the top bits of the three packed groups and forms the report.
// ----------------------------------------------------------------------------
module tbfd_unpack (
    input  tbfd_pkg::t_frame   i_frame,
    output tbfd_pkg::t_result  o_result
);

    tbfd_pkg::t_byte dec [17];

    // Each group ends in a packing byte whose bit i is the top bit of data byte i.
    always_comb begin
        dec[0] = i_frame[0] & tbfd_pkg::LOW7;
        for (int i = 1; i < 7; i++) begin
            dec[i] = i_frame[i] | {i_frame[7][i], 7'b0};
        end
        for (int i = 0; i < 7; i++) begin
            dec[7 + i] = i_frame[8 + i] | {i_frame[15][i], 7'b0};
        end
        for (int i = 0; i < 3; i++) begin
            dec[14 + i] = i_frame[16 + i] | {i_frame[19][i], 7'b0};
        end
        dec[0] = dec[0] | {i_frame[7][0], 7'b0};
    end

    always_comb begin
        o_result.sensor_index = $signed({1'b0, dec[1]} - tbfd_pkg::SENSOR_BASE);
        o_result.pos_x        = $signed({dec[4], dec[3]});
        o_result.pos_y        = $signed({dec[6], dec[5]});
        o_result.pos_z        = $signed({dec[8], dec[7]});
        o_result.quat_w       = $signed({dec[10], dec[9]});
        o_result.quat_x       = $signed({dec[12], dec[11]});
        o_result.quat_y       = $signed({dec[14], dec[13]});
        o_result.quat_z       = $signed({dec[16], dec[15]});
    end

endmodule

[src/tracker_binary_frame_deframer.sv]
// ----------------------------------------------------------------------------
// Tracker binary frame deframer
// Hunts for a sync byte, gathers a 20-byte frame in a chain of byte cells
// and emits one decoded sensor report per frame.
// ----------------------------------------------------------------------------
//  channel | valid      | stall      | payload
//  --------+------------+------------+-----------------------------------------
//  input   | i_rx_valid | o_rx_stall | i_rx_byte
//  output  | o_valid    | i_stall    | o_sensor_index, o_pos_*, o_quat_*
//
// One beat is taken per cycle while the input is not stalled; a report
// leaves in the cycle after the last frame byte, from a single output register.
// The input stalls only while that register is full and stalled and the
// waiting beat would complete a frame; every other beat is taken at once.
// Reset returns the block to hunting; the cell chain holds no reset value.
// ----------------------------------------------------------------------------
`include "tracker_binary_frame_deframer_macros.svh"

module tracker_binary_frame_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [8:0]  o_sensor_index,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);

    logic                              r_hunt;
    logic                              n_hunt;
    logic [tbfd_pkg::COUNT_W-1:0]      r_count;
    logic [tbfd_pkg::COUNT_W-1:0]      n_count;
    logic                              r_out_valid;
    logic                              n_out_valid;
    tbfd_pkg::t_result                 r_result;
    tbfd_pkg::t_result                 dec_result;

    logic            in_accept;
    logic            is_sync;
    logic            last_byte;
    logic            complete;
    logic            shift;
    tbfd_pkg::t_byte chain [tbfd_pkg::CHAIN_LEN];
    tbfd_pkg::t_frame frame;

    assign is_sync   = (i_rx_byte & tbfd_pkg::SYNC_BIT) != 8'h00;
    assign last_byte = !r_hunt && (r_count == tbfd_pkg::LAST_COUNT);
    assign o_rx_stall = r_out_valid && i_stall && last_byte;
    assign in_accept = i_rx_valid && !o_rx_stall;
    assign complete  = in_accept && last_byte;
    assign shift     = in_accept && (!r_hunt || is_sync);

    // Bytes enter at the top cell and move down one place per beat, so after
    // nineteen beats cell k holds frame byte k.
    genvar g;
    generate
        for (g = 0; g < tbfd_pkg::CHAIN_LEN; g++) begin : g_cell
            if (g == tbfd_pkg::CHAIN_LEN - 1) begin : g_top
                tbfd_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift),
                    .i_byte (i_rx_byte),
                    .o_byte (chain[g])
                );
            end else begin : g_mid
                tbfd_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift),
                    .i_byte (chain[g + 1]),
                    .o_byte (chain[g])
                );
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < tbfd_pkg::CHAIN_LEN; i++) begin
            frame[i] = chain[i];
        end
        frame[tbfd_pkg::CHAIN_LEN] = i_rx_byte;
    end

    tbfd_unpack u_unpack (
        .i_frame (frame),
        .o_result(dec_result)
    );

    always_comb begin
        n_hunt  = r_hunt;
        n_count = r_count;
        if (in_accept) begin
            if (r_hunt) begin
                if (is_sync) begin
                    n_hunt  = 1'b0;
                    n_count = tbfd_pkg::COUNT_W'(1);
                end
            end else if (last_byte) begin
                n_hunt  = 1'b1;
                n_count = '0;
            end else begin
                n_count = r_count + tbfd_pkg::COUNT_W'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (complete) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt      <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hunt      <= n_hunt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_result <= dec_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sensor_index = r_result.sensor_index;
    assign o_pos_x        = r_result.pos_x;
    assign o_pos_y        = r_result.pos_y;
    assign o_pos_z        = r_result.pos_z;
    assign o_quat_w       = r_result.quat_w;
    assign o_quat_x       = r_result.quat_x;
    assign o_quat_y       = r_result.quat_y;
    assign o_quat_z       = r_result.quat_z;

    `TBFD_ASSERT_SAME(a_hunt_count_zero, i_clk, i_rst_n, r_hunt, r_count == '0)
    `TBFD_ASSERT_SAME(a_count_in_frame, i_clk, i_rst_n, !r_hunt,
        (r_count != '0) && (r_count <= tbfd_pkg::LAST_COUNT))
    `TBFD_ASSERT_NEXT(a_complete_emits, i_clk, i_rst_n, complete, o_valid && r_hunt)
    `TBFD_ASSERT_NEXT(a_drop_non_sync, i_clk, i_rst_n, in_accept && r_hunt && !is_sync,
        r_hunt)

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker binary frame deframer testbench
// Streams sync-led byte frames, line noise and misaligned bursts into the
// deframer under varied idling and back-pressure. Every decoded report is
// checked against an independent decode of the same byte stream.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_FRAMES  = 25;
    localparam int SETTLE_CYCLES = 10;

    // Scoreboard: follows the frame hunt and holds the reports still owed.
    class report_board;
        bit                  hunting;
        int                  fill;
        tbfd_pkg::t_byte     held_bytes [tbfd_pkg::FRAME_LEN];
        tbfd_pkg::t_result   owed [$];
        int                  errors;
        int                  frames_built;
        int                  reports_checked;

        function new();
            hunting = 1'b1;
            fill    = 0;
        endfunction

        function tbfd_pkg::t_result decode_frame();
            tbfd_pkg::t_byte   dec [17];
            tbfd_pkg::t_result r;
            held_bytes[0] = held_bytes[0] & tbfd_pkg::LOW7;
            for (int i = 0; i < 7; i++) begin
                dec[i]     = held_bytes[i]
                           | (held_bytes[7][i] ? tbfd_pkg::SYNC_BIT : 8'h00);
                dec[7 + i] = held_bytes[8 + i]
                           | (held_bytes[15][i] ? tbfd_pkg::SYNC_BIT : 8'h00);
            end
            for (int i = 0; i < 3; i++) begin
                dec[14 + i] = held_bytes[16 + i]
                            | (held_bytes[19][i] ? tbfd_pkg::SYNC_BIT : 8'h00);
            end
            r.sensor_index = {1'b0, dec[1]} - tbfd_pkg::SENSOR_BASE;
            r.pos_x  = {dec[4],  dec[3]};
            r.pos_y  = {dec[6],  dec[5]};
            r.pos_z  = {dec[8],  dec[7]};
            r.quat_w = {dec[10], dec[9]};
            r.quat_x = {dec[12], dec[11]};
            r.quat_y = {dec[14], dec[13]};
            r.quat_z = {dec[16], dec[15]};
            return r;
        endfunction

        function void note_byte(tbfd_pkg::t_byte b);
            if (hunting) begin
                if ((b & tbfd_pkg::SYNC_BIT) != 8'h00) begin
                    held_bytes[0] = b;
                    fill          = 1;
                    hunting       = 1'b0;
                end
                return;
            end
            held_bytes[fill] = b;
            fill++;
            if (fill == tbfd_pkg::FRAME_LEN) begin
                owed.push_back(decode_frame());
                frames_built++;
                hunting = 1'b1;
                fill    = 0;
            end
        endfunction

        function void compare(string field, logic signed [15:0] want,
                              logic signed [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_report(tbfd_pkg::t_result got);
            tbfd_pkg::t_result want;
            if (owed.size() == 0) begin
                $error("report delivered with no frame outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            reports_checked++;
            compare("sensor_index", want.sensor_index, got.sensor_index);
            compare("pos_x",  want.pos_x,  got.pos_x);
            compare("pos_y",  want.pos_y,  got.pos_y);
            compare("pos_z",  want.pos_z,  got.pos_z);
            compare("quat_w", want.quat_w, got.quat_w);
            compare("quat_x", want.quat_x, got.quat_x);
            compare("quat_y", want.quat_y, got.quat_y);
            compare("quat_z", want.quat_z, got.quat_z);
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_rx_valid = 1'b0;
    logic [7:0]         i_rx_byte  = 8'h00;
    logic               i_stall    = 1'b0;
    logic               o_rx_stall;
    logic               o_valid;
    logic signed [8:0]  o_sensor_index;
    logic signed [15:0] o_pos_x;
    logic signed [15:0] o_pos_y;
    logic signed [15:0] o_pos_z;
    logic signed [15:0] o_quat_w;
    logic signed [15:0] o_quat_x;
    logic signed [15:0] o_quat_y;
    logic signed [15:0] o_quat_z;

    report_board board;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_left     = 0;
    int          cycle_count   = 0;
    int          bytes_taken   = 0;
    int          stalled_beats = 0;

    // Noise, then one frame with set top bits inside it, packing bits that
    // both raise and leave alone top bits, and the largest sensor number.
    tbfd_pkg::t_byte directed_bytes [23] = '{
        8'h00, 8'h7F, 8'h2A,
        8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hD2,
        8'h00, 8'h7F, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h00,
        8'h7F, 8'h7F, 8'h01, 8'hFF
    };

    tracker_binary_frame_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sensor_index (o_sensor_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_quat_w       (o_quat_w),
        .o_quat_x       (o_quat_x),
        .o_quat_y       (o_quat_y),
        .o_quat_z       (o_quat_z)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // A long hold-off takes precedence over the random stall pattern.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_rx_valid && o_rx_stall) begin
            stalled_beats++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_report({o_sensor_index, o_pos_x, o_pos_y, o_pos_z,
                                o_quat_w, o_quat_x, o_quat_y, o_quat_z});
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(input tbfd_pkg::t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        board.note_byte(b);
        bytes_taken++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_reports();
        i_rx_valid <= 1'b0;
        while (board.owed.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic tbfd_pkg::t_byte pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return 8'h31 + tbfd_pkg::t_byte'($urandom_range(3));
            default: return tbfd_pkg::t_byte'($urandom_range(255));
        endcase
    endfunction

    // Mostly whole frames; now and then a short or long burst that throws
    // the framing out of step, with line noise in front.
    task automatic send_random_frame();
        int tail;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(tbfd_pkg::t_byte'($urandom_range(127)));
        end
        tail = ($urandom_range(9) == 0) ? $urandom_range(0, 25) : tbfd_pkg::FRAME_LEN - 1;
        send_byte(tbfd_pkg::SYNC_BIT | tbfd_pkg::t_byte'($urandom_range(127)));
        repeat (tail) send_byte(pick_byte());
    endtask

    task automatic run_phase(input int idle, input int stall, input int frames);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (frames) send_random_frame();
        wait_for_reports();
    endtask

    initial begin
        board = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        wait_for_reports();

        run_phase(0, 0, PHASE_FRAMES);
        run_phase(83, 0, PHASE_FRAMES);
        run_phase(0, 83, PHASE_FRAMES);
        run_phase(9, 9, PHASE_FRAMES);

        // Hold the output off while three frames stream in at full rate, so
        // that the second frame's last beat has to wait.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 150;
        repeat (3) begin
            send_byte(tbfd_pkg::SYNC_BIT | tbfd_pkg::t_byte'($urandom_range(127)));
            repeat (tbfd_pkg::FRAME_LEN - 1) send_byte(pick_byte());
        end
        wait_for_reports();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (board.owed.size() != 0) begin
            $error("%0d reports never delivered", board.owed.size());
            board.errors++;
        end

        $display("tb: %0d bytes taken, %0d frames decoded, %0d reports checked",
                 bytes_taken, board.frames_built, board.reports_checked);
        $display("tb: input held back on %0d beats across idle, stall and hold-off phases",
                 stalled_beats);
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
